// ===== rtl/core/pebl_pkg.sv =====
// ----------------------------------------------------------------------------
// pebl_pkg
// Shared codes and fixed-point constants of the pixel effect blend core.
// ----------------------------------------------------------------------------
package pebl_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_EFFECT_MODE    = 3'd0,
    REG_BLEND_STRENGTH = 3'd1,
    REG_TIME_VALUE     = 3'd2,
    REG_FRAME_WIDTH    = 3'd3,
    REG_FRAME_HEIGHT   = 3'd4
  } reg_idx_t;

  // effect modes
  typedef enum logic [1:0] {
    MODE_PASS   = 2'd0,
    MODE_INVERT = 2'd1,
    MODE_GRAD   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  // phase coefficients, Q.16
  localparam logic [17:0] K_WAVE_X = 18'd183501;
  localparam logic [17:0] K_WAVE_Y = 18'd111411;
  localparam logic [17:0] K_BAND_X = 18'd58982;
  localparam logic [17:0] K_BAND_Y = 18'd150733;
  localparam logic [13:0] K_WAVE_T = 14'd14418;
  localparam logic [13:0] K_BAND_T = 14'd8520;

  // odd sine polynomial, Q2.30
  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598669;
  localparam logic [63:0] SIN_C5 = 64'd85569304;
  localparam logic [63:0] SIN_C7 = 64'd5026996;
  localparam logic [63:0] SIN_C9 = 64'd172272;

  localparam logic [8:0] STRENGTH_FULL = 9'd256;

endpackage

// ===== rtl/core/pixel_effect_blend_core.sv =====
// ----------------------------------------------------------------------------
// pixel_effect_blend_core
// Per-pixel RGBA effect (passthrough, invert, animated gradient) with blend.
// ----------------------------------------------------------------------------
// Six-stage pipeline, one pixel per clock while out_tready is high and no
// reciprocal runs: an accepted request passes through the stages in order
// and leaves as a result; a stall on the output freezes all stages, nothing
// is dropped. The stages are: input register, coordinate normalize multiply,
// phase multiply/add, sine ROM read (two read ports, registered), gradient
// target build, blend multiply and clamp into the output register. Writing
// frame_width or frame_height starts a bit-serial reciprocal; in_tready is low
// while it runs. Other register writes take effect in the next cycle. The user
// must write registers only while no pixel is in flight; it is not enforced.
module pixel_effect_blend_core #(
  parameter int MAX_DIMENSION    = 4096,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  // pixel request in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // column[11:0] row[23:12] red green blue alpha
  // pixel result out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // red[7:0] green[15:8] blue[23:16] alpha[31:24]
);
  import pebl_pkg::*;

  localparam int IDX_W  = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
  localparam int RST_WD = (640 > MAX_DIMENSION) ? MAX_DIMENSION : 640;
  localparam int RST_HT = (480 > MAX_DIMENSION) ? MAX_DIMENSION : 480;
  localparam logic [23:0] COL_SCALE_RST = 24'((1 << 23) / (RST_WD - 1));
  localparam logic [23:0] ROW_SCALE_RST = 24'((1 << 23) / (RST_HT - 1));

  typedef logic [16:0] rom_t [SINE_TABLE_DEPTH];

  // 0.5 + 0.5*sin(2*pi*p/65536), Q1.16
  function automatic logic [16:0] unit_sine(input logic [15:0] p);
    logic [1:0]  quad;
    logic [13:0] r;
    logic [63:0] q, x, x2, acc, mag;
    logic [15:0] half;
    quad = p[15:14];
    r    = p[13:0];
    q    = quad[0] ? (64'd16384 - {50'd0, r}) : {50'd0, r};
    x    = q << 16;
    x2   = (x * x) >> 30;
    acc  = SIN_C9;
    acc  = SIN_C7 - ((x2 * acc) >> 30);
    acc  = SIN_C5 - ((x2 * acc) >> 30);
    acc  = SIN_C3 - ((x2 * acc) >> 30);
    acc  = SIN_C1 - ((x2 * acc) >> 30);
    mag  = ((x * acc) >> 30) >> 14;
    if (mag > 64'd65536) mag = 64'd65536;
    half = 16'(mag >> 1);
    return quad[1] ? (17'd32768 - {1'b0, half}) : (17'd32768 + {1'b0, half});
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      t[i] = unit_sine(16'((i * 65536) / SINE_TABLE_DEPTH));
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // ---------------- configuration ----------------
  logic [1:0]  effect_mode_r;
  logic [8:0]  blend_strength_r;
  logic [15:0] wave_time_phase_r, band_time_phase_r;
  logic [23:0] scale_r [2];       // 0 column, 1 row

  // reciprocal lanes: 2^23 / d, one quotient bit a cycle
  logic [1:0]  div_busy_r, div_busy_nxt;
  logic [4:0]  div_cnt_r [2], div_cnt_nxt [2];
  logic [13:0] div_rem_r [2], div_rem_nxt [2];
  logic [23:0] div_quo_r [2], div_quo_nxt [2];
  logic [12:0] div_d_r [2], div_d_nxt [2];
  logic [1:0]  div_done;

  logic [12:0] dim_c;
  logic        dim_lane_wr [2];

  always_comb begin
    dim_c = ({19'd0, cfg_wdata[12:0]} > MAX_DIMENSION) ? 13'(MAX_DIMENSION)
                                                        : cfg_wdata[12:0];
    dim_lane_wr[0] = cfg_wr_en && (cfg_addr == REG_FRAME_WIDTH);
    dim_lane_wr[1] = cfg_wr_en && (cfg_addr == REG_FRAME_HEIGHT);
  end

  always_comb begin
    logic [13:0] sh;
    for (int l = 0; l < 2; l++) begin
      div_busy_nxt[l] = div_busy_r[l];
      div_cnt_nxt[l]  = div_cnt_r[l];
      div_rem_nxt[l]  = div_rem_r[l];
      div_quo_nxt[l]  = div_quo_r[l];
      div_d_nxt[l]    = div_d_r[l];
      div_done[l]     = 1'b0;
      sh = {div_rem_r[l][12:0], (div_cnt_r[l] == 5'd23)};
      if (dim_lane_wr[l]) begin
        div_busy_nxt[l] = (dim_c >= 13'd2);
        div_cnt_nxt[l]  = 5'd23;
        div_rem_nxt[l]  = '0;
        div_quo_nxt[l]  = '0;
        div_d_nxt[l]    = dim_c - 13'd1;
      end else if (div_busy_r[l]) begin
        if (sh >= {1'b0, div_d_r[l]}) begin
          div_rem_nxt[l] = sh - {1'b0, div_d_r[l]};
          div_quo_nxt[l] = {div_quo_r[l][22:0], 1'b1};
        end else begin
          div_rem_nxt[l] = sh;
          div_quo_nxt[l] = {div_quo_r[l][22:0], 1'b0};
        end
        div_cnt_nxt[l] = div_cnt_r[l] - 5'd1;
        if (div_cnt_r[l] == 5'd0) begin
          div_busy_nxt[l] = 1'b0;
          div_done[l]     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    div_cnt_r <= div_cnt_nxt;
    div_rem_r <= div_rem_nxt;
    div_quo_r <= div_quo_nxt;
    div_d_r   <= div_d_nxt;
    if (!rst_n) begin
      effect_mode_r     <= MODE_PASS;
      blend_strength_r  <= STRENGTH_FULL;
      wave_time_phase_r <= '0;
      band_time_phase_r <= '0;
      scale_r[0]        <= COL_SCALE_RST;
      scale_r[1]        <= ROW_SCALE_RST;
      div_busy_r        <= '0;
    end else begin
      div_busy_r <= div_busy_nxt;
      for (int l = 0; l < 2; l++) begin
        if (dim_lane_wr[l] && dim_c < 13'd2) scale_r[l] <= '0;
        else if (div_done[l])                scale_r[l] <= div_quo_nxt[l];
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_EFFECT_MODE:    effect_mode_r    <= cfg_wdata[1:0];
          REG_BLEND_STRENGTH: blend_strength_r <= cfg_wdata[8:0];
          REG_TIME_VALUE: begin
            wave_time_phase_r <= 16'(({14'd0, cfg_wdata} * {32'd0, K_WAVE_T}) >> 16);
            band_time_phase_r <= 16'(({14'd0, cfg_wdata} * {32'd0, K_BAND_T}) >> 16);
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------- pipeline ----------------
  logic [5:0] vld_r;
  logic       adv;

  assign adv        = !vld_r[5] || out_tready;
  assign in_tready  = adv && (div_busy_r == 2'b00);
  assign out_tvalid = vld_r[5];

  logic [8:0] k_eff;
  assign k_eff = (blend_strength_r > STRENGTH_FULL) ? STRENGTH_FULL : blend_strength_r;

  logic [11:0] col1_r, row1_r;
  logic [7:0]  src1_r [4], src2_r [4], src3_r [4], src4_r [4], src5_r [4];
  logic [28:0] nx2_r, ny2_r, nx3_r, ny3_r, nx4_r, ny4_r;
  logic [15:0] wp3_r, bp3_r;
  logic [16:0] w4_r, b4_r;
  logic [36:0] tgt5_r [3];
  logic [7:0]  alpha5_r;
  logic [7:0]  chan6_r [3];
  logic [7:0]  alpha6_r;

  // stage 2 / 3 arithmetic and stage 4 ROM index
  logic [35:0] nx_full, ny_full;
  logic [46:0] pwx, pwy, pbx, pby;
  logic [15:0] wp_nxt, bp_nxt;
  logic [IDX_W-1:0] widx, bidx;

  always_comb begin
    nx_full = {24'd0, col1_r} * {12'd0, scale_r[0]};
    ny_full = {24'd0, row1_r} * {12'd0, scale_r[1]};
    pwx = {18'd0, nx2_r} * {29'd0, K_WAVE_X};
    pwy = {18'd0, ny2_r} * {29'd0, K_WAVE_Y};
    pbx = {18'd0, nx2_r} * {29'd0, K_BAND_X};
    pby = {18'd0, ny2_r} * {29'd0, K_BAND_Y};
    wp_nxt = pwx[31:16] + pwy[31:16] - wave_time_phase_r;
    bp_nxt = pbx[31:16] - pby[31:16] + band_time_phase_r;
    widx = IDX_W'(({16'd0, wp3_r} * 32'(SINE_TABLE_DEPTH)) >> 16);
    bidx = IDX_W'(({16'd0, bp3_r} * 32'(SINE_TABLE_DEPTH)) >> 16);
  end

  // stage 5 targets, Q.16
  logic [36:0] tgt_nxt [3];
  logic [7:0]  alpha_nxt;

  always_comb begin
    alpha_nxt = src4_r[3];
    for (int c = 0; c < 3; c++) tgt_nxt[c] = {13'd0, src4_r[c], 16'd0};
    case (effect_mode_r)
      MODE_INVERT: begin
        for (int c = 0; c < 3; c++) tgt_nxt[c] = {13'd0, 8'd255 - src4_r[c], 16'd0};
      end
      MODE_GRAD: begin
        tgt_nxt[0] = 37'd1179648 + 37'd122 * {20'd0, w4_r} + 37'd62 * {8'd0, ny4_r};
        tgt_nxt[1] = 37'd1835008 + 37'd112 * (37'd65536 - {20'd0, w4_r})
                     + 37'd74 * {8'd0, nx4_r};
        tgt_nxt[2] = 37'd4456448 + 37'd154 * {20'd0, b4_r};
        alpha_nxt  = 8'd255;
      end
      default: ;
    endcase
  end

  // stage 6 blend: s*(256-k) + t*k with s the source in Q.16, never negative
  logic [46:0] v [3];
  logic [7:0]  chan_nxt [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v[c] = {23'd0, src5_r[c], 16'd0} * {38'd0, STRENGTH_FULL - k_eff}
             + {10'd0, tgt5_r[c]} * {38'd0, k_eff};
      chan_nxt[c] = (v[c][46:24] > 23'd255) ? 8'd255 : v[c][31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_tvalid && in_tready};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col1_r <= in_tdata[11:0];
      row1_r <= in_tdata[23:12];
      for (int c = 0; c < 4; c++) src1_r[c] <= in_tdata[24 + 8*c +: 8];
      nx2_r  <= nx_full[35:7];
      ny2_r  <= ny_full[35:7];
      src2_r <= src1_r;
      wp3_r  <= wp_nxt;
      bp3_r  <= bp_nxt;
      nx3_r  <= nx2_r;
      ny3_r  <= ny2_r;
      src3_r <= src2_r;
      w4_r   <= SINE_ROM[widx];
      b4_r   <= SINE_ROM[bidx];
      nx4_r  <= nx3_r;
      ny4_r  <= ny3_r;
      src4_r <= src3_r;
      tgt5_r   <= tgt_nxt;
      alpha5_r <= alpha_nxt;
      src5_r   <= src4_r;
      chan6_r  <= chan_nxt;
      alpha6_r <= alpha5_r;
    end
  end

  assign out_tdata = {alpha6_r, chan6_r[2], chan6_r[1], chan6_r[0]};

`ifndef ASSERT_OFF
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valids moved during output stall");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (div_busy_r == 2'b00) && adv)
    else $error("request accepted while reciprocal running or stalled");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr_en && cfg_addr == REG_FRAME_WIDTH && cfg_wdata[12:0] >= 13'd2)
    |=> div_busy_r[0] && div_cnt_r[0] == 5'd23)
    else $error("width write did not start reciprocal");
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (div_busy_r[1] && div_cnt_r[1] == 5'd0 && !dim_lane_wr[1]) |=> !div_busy_r[1])
    else $error("row reciprocal overran");
`endif

endmodule

// ===== test/tb_pixel_effect_blend_core.sv =====
// ----------------------------------------------------------------------------
// tb_pixel_effect_blend_core
// Self-checking bench for the pixel effect blend core: drives pixel requests
// under random flow control, predicts every blended RGBA result in the bench
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_pixel_effect_blend_core;
  import pebl_pkg::*;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // column[11:0] row[23:12] red green blue alpha
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // red[7:0] green[15:8] blue[23:16] alpha[31:24]

  pixel_effect_blend_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  // bench copy of the block's configuration and derived state
  logic [1:0]  sh_mode;
  logic [8:0]  sh_strength;
  logic [31:0] sh_time;
  logic [12:0] sh_width;
  logic [12:0] sh_height;
  logic [23:0] col_scale;
  logic [23:0] row_scale;
  logic [15:0] wave_tphase;
  logic [15:0] band_tphase;

  rgba_t expected_pixels[$];
  int    n_errors;
  int    n_requests;
  int    n_results;
  bit    quiet;        // no idling on either side
  bit    hold_request; // asks the receiver for a long stall
  int    hold_cycles;
  int    ready_gap;

  function automatic logic [23:0] recip_scale(logic [12:0] dim);
    logic [31:0] d;
    d = dim;
    if (d > 4096) d = 4096;
    if (d < 2) return 24'd0;
    return 24'((32'd1 << 23) / (d - 1));
  endfunction

  function automatic void shadow_write(reg_idx_t idx, logic [31:0] val);
    case (idx)
      REG_EFFECT_MODE:    sh_mode = val[1:0];
      REG_BLEND_STRENGTH: sh_strength = val[8:0];
      REG_TIME_VALUE: begin
        sh_time = val;
        wave_tphase = 16'((64'(val) * 64'(K_WAVE_T)) >> 16);
        band_tphase = 16'((64'(val) * 64'(K_BAND_T)) >> 16);
      end
      REG_FRAME_WIDTH: begin
        sh_width = val[12:0];
        col_scale = recip_scale(val[12:0]);
      end
      REG_FRAME_HEIGHT: begin
        sh_height = val[12:0];
        row_scale = recip_scale(val[12:0]);
      end
      default: ;
    endcase
  endfunction

  function automatic void shadow_reset();
    shadow_write(REG_EFFECT_MODE, 32'd0);
    shadow_write(REG_BLEND_STRENGTH, 32'd256);
    shadow_write(REG_TIME_VALUE, 32'd0);
    shadow_write(REG_FRAME_WIDTH, 32'd640);
    shadow_write(REG_FRAME_HEIGHT, 32'd480);
  endfunction

  // 0.5 + 0.5*sin of a Q0.16 phase, quantized to the table depth, Q1.16
  function automatic logic [63:0] half_sine(logic [15:0] phase);
    logic [63:0] idx, p, quad, r, q, x, x2, acc, mag, half;
    idx  = (64'(phase) * 1024) >> 16;
    p    = (idx * 65536) / 1024;
    quad = (p >> 14) & 3;
    r    = p & 64'h3FFF;
    q    = quad[0] ? 64'd16384 - r : r;
    x    = q << 16;
    x2   = (x * x) >> 30;
    acc  = SIN_C9;
    acc  = SIN_C7 - ((x2 * acc) >> 30);
    acc  = SIN_C5 - ((x2 * acc) >> 30);
    acc  = SIN_C3 - ((x2 * acc) >> 30);
    acc  = SIN_C1 - ((x2 * acc) >> 30);
    mag  = ((x * acc) >> 30) >> 14;
    if (mag > 65536) mag = 65536;
    half = mag >> 1;
    return quad >= 2 ? 64'd32768 - half : 64'd32768 + half;
  endfunction

  function automatic logic [7:0] blend_byte(logic [7:0] src, longint target, longint k);
    longint s, v;
    s = longint'(src) * 65536;
    v = s * 256 + (target - s) * k;
    if (v < 0) return 8'd0;
    if ((v >>> 24) > 255) return 8'd255;
    return 8'(v >>> 24);
  endfunction

  function automatic rgba_t blended_pixel(logic [55:0] d);
    logic [11:0] col, row;
    logic [7:0]  sr, sg, sb, sa;
    logic [63:0] nx, ny, wp, bp;
    longint      k, tr, tg, tb, w, bd;
    rgba_t       px;
    col = d[11:0];  row = d[23:12];
    sr = d[31:24];  sg = d[39:32];  sb = d[47:40];  sa = d[55:48];
    k  = sh_strength > 256 ? 256 : sh_strength;
    nx = (64'(col) * 64'(col_scale)) >> 7;
    ny = (64'(row) * 64'(row_scale)) >> 7;
    tr = longint'(sr) * 65536;
    tg = longint'(sg) * 65536;
    tb = longint'(sb) * 65536;
    px.alpha = sa;
    if (sh_mode == MODE_INVERT) begin
      tr = longint'(255 - sr) * 65536;
      tg = longint'(255 - sg) * 65536;
      tb = longint'(255 - sb) * 65536;
    end else if (sh_mode == MODE_GRAD) begin
      wp = (((nx * K_WAVE_X) >> 16) + ((ny * K_WAVE_Y) >> 16) - wave_tphase) & 64'hFFFF;
      bp = (((nx * K_BAND_X) >> 16) - ((ny * K_BAND_Y) >> 16) + band_tphase) & 64'hFFFF;
      w  = longint'(half_sine(wp[15:0]));
      bd = longint'(half_sine(bp[15:0]));
      tr = 18 * 65536 + 122 * w + 62 * longint'(ny);
      tg = 28 * 65536 + 112 * (65536 - w) + 74 * longint'(nx);
      tb = 68 * 65536 + 154 * bd;
      px.alpha = 8'd255;
    end
    px.red   = blend_byte(sr, tr, k);
    px.green = blend_byte(sg, tg, k);
    px.blue  = blend_byte(sb, tb, k);
    return px;
  endfunction

  // receiver: random stall bursts, a long hold on request, none when quiet
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_cycles  = 300;
      out_tready  <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0) ready_gap = $urandom_range(1, 15);
    end
  end

  // result checker
  always @(posedge clk) begin
    rgba_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      n_results++;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        n_errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.red) begin
          $error("red_out expected %0d got %0d", want.red, got.red); n_errors++;
        end
        if (got.green !== want.green) begin
          $error("green_out expected %0d got %0d", want.green, got.green); n_errors++;
        end
        if (got.blue !== want.blue) begin
          $error("blue_out expected %0d got %0d", want.blue, got.blue); n_errors++;
        end
        if (got.alpha !== want.alpha) begin
          $error("alpha_out expected %0d got %0d", want.alpha, got.alpha); n_errors++;
        end
      end
    end
  end

  // one pixel request; valid stays high into the next request unless a gap
  task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [7:0] r,
                            logic [7:0] g, logic [7:0] b, logic [7:0] a);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {a, b, g, r, row, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_pixels.push_back(blended_pixel({a, b, g, r, row, col}));
    n_requests++;
  endtask

  task automatic send_random_pixel();
    logic [11:0] col, row;
    col = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, sh_width));
    row = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, sh_height));
    send_pixel(col, row, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // only called with nothing in flight
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_write(idx, val);
    @(posedge clk);
  endtask

  task automatic write_all(logic [1:0] m, logic [8:0] k, logic [31:0] t,
                           logic [12:0] w, logic [12:0] h);
    write_reg(REG_EFFECT_MODE, 32'(m));
    write_reg(REG_BLEND_STRENGTH, 32'(k));
    write_reg(REG_TIME_VALUE, t);
    write_reg(REG_FRAME_WIDTH, 32'(w));
    write_reg(REG_FRAME_HEIGHT, 32'(h));
  endtask

  // reset values in effect before any write
  task automatic test_reset_defaults();
    send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(12'd639, 12'd479, 8'd255, 8'd255, 8'd255, 8'd255);
  endtask

  // field extremes in every mode, strength extremes, odd frame sizes
  task automatic test_directed();
    logic [1:0] m;
    for (int i = 0; i < 4; i++) begin
      m = 2'(i);
      write_all(m, 9'd256, 32'd0, 13'd640, 13'd480);
      send_pixel(12'd0, 12'd0, 8'd0, 8'd255, 8'd0, 8'd255);
      send_pixel(12'd4095, 12'd4095, 8'd255, 8'd0, 8'd255, 8'd0);
    end
    write_all(MODE_GRAD, 9'd0, 32'hFFFF_FFFF, 13'd1, 13'd0);
    send_pixel(12'd100, 12'd200, 8'd12, 8'd34, 8'd56, 8'd78);
    write_all(MODE_GRAD, 9'd511, 32'h0001_8000, 13'd8191, 13'd4097);
    send_pixel(12'd4095, 12'd0, 8'd200, 8'd100, 8'd50, 8'd1);
    write_all(MODE_INVERT, 9'd300, 32'd0, 13'd2, 13'd2);
    send_pixel(12'd3, 12'd1, 8'd1, 8'd128, 8'd254, 8'd9);
    write_all(MODE_GRAD, 9'd128, 32'h0003_0000, 13'd4096, 13'd1);
    send_pixel(12'd2048, 12'd0, 8'd128, 8'd128, 8'd128, 8'd128);
    send_pixel(12'd4095, 12'd4095, 8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  // random phases, each under a new random configuration
  task automatic test_random(int phases, int per_phase);
    logic [12:0] w, h;
    for (int ph = 0; ph < phases; ph++) begin
      w = $urandom_range(0, 9) == 0 ? 13'($urandom) : 13'($urandom_range(2, 1024));
      h = $urandom_range(0, 9) == 0 ? 13'($urandom) : 13'($urandom_range(2, 1024));
      write_all($urandom_range(0, 9) < 6 ? MODE_GRAD : 2'($urandom),
                $urandom_range(0, 3) == 0 ? 9'($urandom) : 9'($urandom_range(0, 256)),
                $urandom, w, h);
      repeat (per_phase) send_random_pixel();
    end
  endtask

  // receiver stalls long while requests keep coming
  task automatic test_backpressure();
    write_all(MODE_GRAD, 9'd200, $urandom, 13'd320, 13'd240);
    hold_request = 1'b1;
    repeat (60) send_random_pixel();
  endtask

  initial begin
    int wait_cycles;
    clk = 1'b0; rst_n = 1'b0;
    cfg_wr_en = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tdata = '0;
    n_errors = 0; n_requests = 0; n_results = 0;
    quiet = 1'b0; hold_request = 1'b0; hold_cycles = 0; ready_gap = 0;
    shadow_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_random(12, 130);
    quiet = 1'b1;           // final stretch runs at full rate
    test_random(2, 120);

    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (expected_pixels.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d results never arrived", expected_pixels.size());
      n_errors++;
    end
    $display("ran %0d pixel requests, %0d results checked", n_requests, n_results);
    $display("all modes, strength and frame size extremes, random flow control");
    if (n_errors == 0) begin
      $display("[pixel_effect_blend_core] OK");
    end else begin
      $display("[pixel_effect_blend_core] ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("[pixel_effect_blend_core] ERROR");
    $finish;
  end

endmodule
